// ----- rtl/atl_pkg.sv -----
// Shared types, constants and character-class functions for the assembler token lexer.
// Used by atl_front, atl_fifo, atl_back and assembler_token_lexer_core.
package atl_pkg;

  localparam int MaxLine   = 1024;
  localparam int ColW      = 10;
  localparam int ColMax    = (MaxLine - 1) < 1023 ? (MaxLine - 1) : 1023;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [10:0] {
    S_START   = 11'b000_0000_0001,
    S_ID      = 11'b000_0000_0010,
    S_LABEL   = 11'b000_0000_0100,
    S_NUM     = 11'b000_0000_1000,
    S_VAR     = 11'b000_0001_0000,
    S_DOLLAR  = 11'b000_0010_0000,
    S_COMMENT = 11'b000_0100_0000,
    S_WS      = 11'b000_1000_0000,
    S_ZERO    = 11'b001_0000_0000,
    S_ZEROX   = 11'b010_0000_0000,
    S_COMMA   = 11'b100_0000_0000
  } lex_state_e;

  typedef enum logic [2:0] {
    KIND_ID    = 3'd0,
    KIND_LABEL = 3'd1,
    KIND_NUM   = 3'd2,
    KIND_VAR   = 3'd3,
    KIND_COMMA = 3'd4,
    KIND_ZERO  = 3'd5,
    KIND_ERROR = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ColW-1:0]   start;
    logic [ColW-1:0]   len;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  typedef struct packed {
    logic  ok;
    lex_state_e state;
  } trans_t;

  typedef struct packed {
    logic  accept;
    logic  emit;
    kind_e kind;
  } info_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic trans_t next_state(lex_state_e s, logic [7:0] c);
    trans_t t;
    t.ok    = 1'b0;
    t.state = S_START;
    if (!c[7]) begin
      unique case (s) inside
        S_START: begin
          t.ok = 1'b1;
          if (is_alpha(c)) t.state = S_ID;
          else if (c >= 8'h31 && c <= 8'h39) t.state = S_NUM;
          else if (c == 8'h23) t.state = S_COMMENT;
          else if (is_space(c)) t.state = S_WS;
          else if (c == 8'h2c) t.state = S_COMMA;
          else if (c == 8'h24) t.state = S_DOLLAR;
          else if (c == 8'h30) t.state = S_ZERO;
          else t.ok = 1'b0;
        end
        S_ID: begin
          if (is_alpha(c)) begin
            t.ok = 1'b1;
            t.state = S_ID;
          end else if (c == 8'h3a) begin
            t.ok = 1'b1;
            t.state = S_LABEL;
          end
        end
        S_WS: begin
          t.ok = is_space(c);
          t.state = S_WS;
        end
        S_DOLLAR, S_VAR: begin
          t.ok = is_digit(c);
          t.state = S_VAR;
        end
        S_COMMENT: begin
          t.ok = c != 8'h0a;
          t.state = S_COMMENT;
        end
        S_NUM, S_ZEROX: begin
          t.ok = is_hex(c);
          t.state = S_NUM;
        end
        S_ZERO: begin
          t.ok = c == 8'h78;
          t.state = S_ZEROX;
        end
        default: t.ok = 1'b0;
      endcase
    end
    return t;
  endfunction

  function automatic info_t state_info(lex_state_e s);
    info_t i;
    i.accept = 1'b1;
    i.emit   = 1'b1;
    i.kind   = KIND_ERROR;
    unique case (s) inside
      S_ID:      i.kind = KIND_ID;
      S_LABEL:   i.kind = KIND_LABEL;
      S_NUM:     i.kind = KIND_NUM;
      S_VAR:     i.kind = KIND_VAR;
      S_COMMA:   i.kind = KIND_COMMA;
      S_ZERO:    i.kind = KIND_ZERO;
      S_COMMENT, S_WS: i.emit = 1'b0;
      default: begin
        i.accept = 1'b0;
        i.emit   = 1'b0;
      end
    endcase
    return i;
  endfunction

  function automatic logic [ColW-1:0] sat_len(logic [ColW-1:0] diff, logic plus_one);
    logic [ColW:0] l;
    l = {1'b0, diff} + {{ColW{1'b0}}, plus_one};
    return l[ColW] ? {ColW{1'b1}} : l[ColW-1:0];
  endfunction

endpackage

// ----- rtl/atl_front.sv -----
// Front part: accepts characters, runs the maximal-munch state machine and
// packs the results of each character into one record. Depends on atl_pkg.
module atl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    ch_i,
  input  logic          line_end_i,
  output logic          in_ready_o,
  input  logic          full_i,
  output logic          push_o,
  output atl_pkg::rec_t rec_o
);
  import atl_pkg::*;

  lex_state_e      state_q, state_d;
  logic [ColW-1:0] col_q, col_d, tstart_q, tstart_d;
  logic            skip_q, skip_d;

  trans_t          t0, t1;
  info_t           info_cur, info_new;
  logic [ColW-1:0] st, st_new, col_inc;
  lex_state_e      t_new;
  logic            err, emit_a, emit_b, accept;
  res_t            res_a, res_b;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign col_inc    = (col_q < ColW'(ColMax)) ? col_q + 1'b1 : ColW'(ColMax);

  always_comb begin
    st       = (state_q == S_START) ? col_q : tstart_q;
    t0       = next_state(state_q, ch_i);
    t1       = next_state(S_START, ch_i);
    info_cur = state_info(state_q);
    err      = 1'b0;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    res_a    = '{kind: KIND_ERROR, start: st, len: sat_len(col_q - st, 1'b1)};
    res_b    = res_a;
    st_new   = st;
    t_new    = t0.state;
    if (!t0.ok) begin
      if (!info_cur.accept) begin
        emit_a = 1'b1;
        err    = 1'b1;
      end else begin
        emit_a = info_cur.emit;
        res_a  = '{kind: info_cur.kind, start: st, len: sat_len(col_q - st, 1'b0)};
        st_new = col_q;
        t_new  = t1.state;
        if (!t1.ok) begin
          emit_b = 1'b1;
          err    = 1'b1;
          res_b  = '{kind: KIND_ERROR, start: col_q, len: ColW'(1)};
        end
      end
    end
    info_new = state_info(t_new);
    if (!err && line_end_i) begin
      emit_b = !info_new.accept || info_new.emit;
      res_b  = '{kind: info_new.accept ? info_new.kind : KIND_ERROR,
                 start: st_new, len: sat_len(col_q - st_new, 1'b1)};
    end
  end

  always_comb begin
    rec_o.two = emit_a && emit_b;
    rec_o.r0  = emit_a ? res_a : res_b;
    rec_o.r1  = res_b;
    push_o    = accept && !skip_q && (emit_a || emit_b);
  end

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    tstart_d = tstart_q;
    skip_d   = skip_q;
    if (accept) begin
      if (line_end_i) begin
        state_d  = S_START;
        col_d    = '0;
        tstart_d = '0;
        skip_d   = 1'b0;
      end else if (!skip_q) begin
        col_d = col_inc;
        if (err) begin
          skip_d   = 1'b1;
          state_d  = S_START;
          tstart_d = '0;
        end else begin
          state_d  = t_new;
          tstart_d = st_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_START;
      col_q    <= '0;
      tstart_q <= '0;
      skip_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      tstart_q <= tstart_d;
      skip_q   <= skip_d;
    end
  end

  a_skip_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> state_q == S_START)
    else $error("Skipped line left the lexer outside the start state.");

  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && line_end_i |=> col_q == '0 && !skip_q)
    else $error("Line end did not restart the column.");

endmodule

// ----- rtl/atl_fifo.sv -----
// Short queue of result records between the lexer front and the output back.
// Depends on atl_pkg for the record type and depth.
module atl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  atl_pkg::rec_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output atl_pkg::rec_t data_o
);
  import atl_pkg::*;

  rec_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(FifoDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Word pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("Word popped from an empty queue.");

endmodule

// ----- rtl/atl_back.sv -----
// Back part: takes result records from the queue and sends their one or two
// results out through a registered output. Depends on atl_pkg.
module atl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  atl_pkg::rec_t q_data_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    kind_o,
  output logic [9:0]    start_col_o,
  output logic [9:0]    length_o,
  output logic          last_of_run_o
);
  import atl_pkg::*;

  rec_t rec_q;
  logic have_q, idx_q;
  res_t cur;
  logic last;

  assign cur           = idx_q ? rec_q.r1 : rec_q.r0;
  assign last          = idx_q || !rec_q.two;
  assign pop_o         = q_valid_i && (!have_q || (out_ready_i && last));
  assign out_valid_o   = have_q;
  assign kind_o        = cur.kind;
  assign start_col_o   = cur.start;
  assign length_o      = cur.len;
  assign last_of_run_o = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      idx_q  <= 1'b0;
    end else if (pop_o) begin
      have_q <= 1'b1;
      idx_q  <= 1'b0;
    end else if (have_q && out_ready_i) begin
      if (last) have_q <= 1'b0;
      else idx_q <= 1'b1;
    end
  end

  a_second_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q && idx_q |-> rec_q.two)
    else $error("Second result sent from a record that holds only one.");

endmodule

// ----- rtl/assembler_token_lexer_core.sv -----
// Top level of the assembler token lexer: front state machine, record queue
// and output sequencer. Depends on atl_pkg, atl_front, atl_fifo and atl_back.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i/in_ready_o  | ch_i, line_end_i
//   out     | output    | out_valid_o/out_ready_i| kind_o, start_col_o, length_o, last_of_run_o
//
// One character is taken per cycle while the queue is not full; its state transition is
// decided in that same cycle. Each character gives zero, one or two results; the back sends
// one result per cycle while out_ready_i is high. The queue holds four records, and input
// ready drops only when it is full. Each record goes through the queue to the output register.
// Reset is asynchronous and active low and puts the lexer at the start of a line.
module assembler_token_lexer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [9:0] start_col_o,
  output logic [9:0] length_o,
  output logic       last_of_run_o
);
  import atl_pkg::*;

  logic push, full, pop, q_valid;
  rec_t push_rec, q_rec;

  atl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .ch_i       (ch_i),
    .line_end_i (line_end_i),
    .in_ready_o (in_ready_o),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  atl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_rec)
  );

  atl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_rec),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .start_col_o   (start_col_o),
    .length_o      (length_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for assembler_token_lexer_core: drives character words with line-end
// flags and checks every token word against a predictor of the maximal-munch lexer.
// Depends on atl_pkg for the lexer state and token kind types.
`timescale 1ns / 100ps

module testbench;
  import atl_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [9:0] start;
    logic [9:0] len;
    logic       last;
  } token_t;

  class token_tracker;
    token_t     tokens_due[$];
    lex_state_e state     = S_START;
    int         column    = 0;
    int         tok_start = 0;
    bit         skip      = 1'b0;
    int         errors    = 0;
    int         chars_taken = 0;

    function bit is_letter(bit [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_num(bit [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_blank(bit [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit is_hexdig(bit [7:0] c);
      return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function bit step_state(lex_state_e s, bit [7:0] c, output lex_state_e nxt);
      nxt = S_START;
      if (c[7]) return 1'b0;
      case (s)
        S_START: begin
          if (is_letter(c)) nxt = S_ID;
          else if (c >= "1" && c <= "9") nxt = S_NUM;
          else if (c == "#") nxt = S_COMMENT;
          else if (is_blank(c)) nxt = S_WS;
          else if (c == ",") nxt = S_COMMA;
          else if (c == "$") nxt = S_DOLLAR;
          else if (c == "0") nxt = S_ZERO;
          else return 1'b0;
          return 1'b1;
        end
        S_ID: begin
          if (is_letter(c)) nxt = S_ID;
          else if (c == ":") nxt = S_LABEL;
          else return 1'b0;
          return 1'b1;
        end
        S_WS: begin
          nxt = S_WS;
          return is_blank(c);
        end
        S_DOLLAR, S_VAR: begin
          nxt = S_VAR;
          return is_num(c);
        end
        S_COMMENT: begin
          nxt = S_COMMENT;
          return c != 8'd10;
        end
        S_NUM, S_ZEROX: begin
          nxt = S_NUM;
          return is_hexdig(c);
        end
        S_ZERO: begin
          nxt = S_ZEROX;
          return c == "x";
        end
        default: return 1'b0;
      endcase
    endfunction

    function bit accepts(lex_state_e s, output bit emits, output kind_e k);
      emits = 1'b1;
      k = KIND_ERROR;
      case (s)
        S_ID:    k = KIND_ID;
        S_LABEL: k = KIND_LABEL;
        S_NUM:   k = KIND_NUM;
        S_VAR:   k = KIND_VAR;
        S_COMMA: k = KIND_COMMA;
        S_ZERO:  k = KIND_ZERO;
        S_COMMENT, S_WS: emits = 1'b0;
        default: begin
          emits = 1'b0;
          return 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    function void queue_token(kind_e k, int st, int len);
      token_t rec;
      rec.kind  = k;
      rec.start = st[9:0];
      rec.len   = (len > 1023) ? 10'd1023 : len[9:0];
      rec.last  = 1'b0;
      tokens_due.insert(tokens_due.size(), rec);
    endfunction

    function void restart();
      state     = S_START;
      column    = 0;
      tok_start = 0;
      skip      = 1'b0;
    endfunction

    function void take_char(bit [7:0] c, bit eol);
      int         col;
      int         st;
      int         first;
      bit         ok;
      bit         err;
      bit         emits;
      lex_state_e nxt;
      kind_e      k;
      chars_taken++;
      first = tokens_due.size();
      col = column;
      err = 1'b0;
      if (skip) begin
        if (eol) restart();
        return;
      end
      st = (state == S_START) ? col : tok_start;
      ok = step_state(state, c, nxt);
      if (!ok) begin
        if (!accepts(state, emits, k)) begin
          queue_token(KIND_ERROR, st, col - st + 1);
          err = 1'b1;
        end else begin
          if (emits) queue_token(k, st, col - st);
          st = col;
          ok = step_state(S_START, c, nxt);
          if (!ok) begin
            queue_token(KIND_ERROR, col, 1);
            err = 1'b1;
          end
        end
      end
      if (!err) begin
        tok_start = st;
        state = nxt;
        if (eol) begin
          if (!accepts(state, emits, k)) queue_token(KIND_ERROR, st, col - st + 1);
          else if (emits) queue_token(k, st, col - st + 1);
        end
      end
      if (eol) begin
        restart();
      end else begin
        if (err) begin
          skip = 1'b1;
          state = S_START;
          tok_start = 0;
        end
        if (column < ColMax) column++;
      end
      if (tokens_due.size() > first) tokens_due[$].last = 1'b1;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("MISMATCH: %s", msg);
    endtask

    task check_token(logic [2:0] kind, logic [9:0] start, logic [9:0] len, logic last);
      token_t want;
      if (tokens_due.size() == 0) begin
        report($sformatf("unexpected word kind %0d col %0d len %0d", kind, start, len));
        return;
      end
      want = tokens_due.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, wanted %0d", kind, want.kind));
      if (start !== want.start)
        report($sformatf("start_col %0d, wanted %0d", start, want.start));
      if (len !== want.len)
        report($sformatf("length %0d, wanted %0d", len, want.len));
      if (last !== want.last)
        report($sformatf("last_of_run %0b, wanted %0b", last, want.last));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] ch_i;
  logic       line_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] kind_o;
  logic [9:0] start_col_o;
  logic [9:0] length_o;
  logic       last_of_run_o;

  token_tracker sb = new();

  bit [7:0] text_q[$];
  bit       eol_q[$];
  int       drain_a;
  int       drain_b;
  int       calm_at;
  bit       calm = 1'b0;
  bit       held = 1'b0;

  string hex_digits = "0123456789abcdefABCDEF";

  assembler_token_lexer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .line_end_i   (line_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .start_col_o  (start_col_o),
    .length_o     (length_o),
    .last_of_run_o(last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic push_ch(bit [7:0] c);
    text_q.insert(text_q.size(), c);
    eol_q.insert(eol_q.size(), 1'b0);
  endtask

  task automatic push_text(string s, bit eol);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
    if (eol) eol_q[$] = 1'b1;
  endtask

  function automatic bit [7:0] pick_letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range(97, 122));
    return 8'($urandom_range(65, 90));
  endfunction

  function automatic bit [7:0] pick_blank();
    int r;
    r = $urandom_range(0, 6);
    return (r >= 5) ? 8'd32 : 8'(9 + r);
  endfunction

  task automatic add_token();
    case ($urandom_range(0, 7))
      0, 1: begin
        repeat ($urandom_range(1, 6)) push_ch(pick_letter());
        if ($urandom_range(0, 2) == 0) push_ch(":");
      end
      2: begin
        push_ch(8'($urandom_range(49, 57)));
        repeat ($urandom_range(0, 4)) push_ch(hex_digits[$urandom_range(0, 21)]);
      end
      3: begin
        push_ch("0");
        if ($urandom_range(0, 2) != 0) begin
          push_ch("x");
          repeat ($urandom_range(0, 3)) push_ch(hex_digits[$urandom_range(0, 21)]);
        end
      end
      4: begin
        push_ch("$");
        repeat ($urandom_range(0, 3)) push_ch(8'($urandom_range(48, 57)));
      end
      5: push_ch(",");
      default: repeat ($urandom_range(1, 3)) push_ch(pick_blank());
    endcase
  endtask

  task automatic add_line(bit broken);
    int ntok;
    int cut;
    ntok = $urandom_range(1, 8);
    cut = $urandom_range(0, ntok - 1);
    for (int t = 0; t < ntok; t++) begin
      add_token();
      if (broken && t == cut) push_ch(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 3))
        1: push_ch(" ");
        2: push_ch(",");
        3: push_text(", ", 1'b0);
        default: ;
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      push_ch("#");
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 11))
          0: push_ch(8'd10);
          1: push_ch(8'($urandom_range(128, 255)));
          default: push_ch(8'($urandom_range(32, 126)));
        endcase
      end
    end
    eol_q[$] = 1'b1;
  endtask

  task automatic build_stimulus();
    int target;
    int long_len;
    int base;
    bit long_done;
    long_len = 0;
    long_done = 1'b0;
    push_text("a zZ: 9f,0 $1#", 1'b1);
    push_text("$x!", 1'b1);
    push_text("0x", 1'b1);
    push_ch(8'h80);
    push_ch(8'hff);
    eol_q[$] = 1'b1;
    push_text("0", 1'b1);
    drain_a = text_q.size();
    target = text_q.size() + 700;
    while (text_q.size() - long_len < target) begin
      case ($urandom_range(0, 9))
        7, 8: add_line(1'b1);
        9: begin
          repeat ($urandom_range(1, 20)) push_ch(8'($urandom_range(0, 255)));
          eol_q[$] = 1'b1;
        end
        default: add_line(1'b0);
      endcase
      if (!long_done && text_q.size() >= target / 2) begin
        drain_b = text_q.size();
        base = text_q.size();
        repeat (1030) push_ch(pick_letter());
        push_text(" 7", 1'b1);
        repeat (8) push_text("9,", 1'b0);
        push_ch(8'($urandom_range(97, 122)));
        eol_q[$] = 1'b1;
        long_len = text_q.size() - base;
        long_done = 1'b1;
      end
    end
    calm_at = text_q.size() - text_q.size() / 8;
  endtask

  task automatic send_all();
    for (int i = 0; i < text_q.size(); i++) begin
      calm = (i >= calm_at);
      if (i == drain_a || i == drain_b) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      ch_i       <= text_q[i];
      line_end_i <= eol_q[i];
      do @(posedge clk_i); while (in_ready_o !== 1'b1);
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.take_char(ch_i, line_end_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_token(kind_o, start_col_o, length_o, last_of_run_o);
  end

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && sb.chars_taken >= 60) begin
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    ch_i       <= 8'd0;
    line_end_i <= 1'b0;
    build_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_all();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TIMEOUT: %0d words still due", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/atl_pkg.sv
rtl/atl_front.sv
rtl/atl_fifo.sv
rtl/atl_back.sv
rtl/assembler_token_lexer_core.sv
verif/testbench.sv
